// File: hw/rtl/timer_compare_capture_pwm_top_defines.svh
// ---------------------------------------------------------------------------
// assertion macros used by the timer checker
// ---------------------------------------------------------------------------
`ifndef TIMER_COMPARE_CAPTURE_PWM_TOP_DEFINES_SVH
`define TIMER_COMPARE_CAPTURE_PWM_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define TCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer assertion failed");

// next-cycle implication, masked during reset
`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer assertion failed");

// next-cycle implication, checked through reset as well
`define TCC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("timer assertion failed");

`endif

// File: hw/rtl/tcc_pkg.sv
// ---------------------------------------------------------------------------
// tcc_pkg
// types and codes shared by the timer compare/capture/pwm block
// ---------------------------------------------------------------------------
package tcc_pkg;

   // request function codes
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_STOP  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;

   // compare output modes
   localparam logic [2:0] MODE_FROZEN = 3'd0;
   localparam logic [2:0] MODE_SET    = 3'd1;
   localparam logic [2:0] MODE_CLEAR  = 3'd2;
   localparam logic [2:0] MODE_TOGGLE = 3'd3;
   localparam logic [2:0] MODE_PWM    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_PRESCALE       = 3'd0;
   localparam logic [2:0] REG_AUTO_RELOAD    = 3'd1;
   localparam logic [2:0] REG_COMPARE_VALUE  = 3'd2;
   localparam logic [2:0] REG_COMPARE_MODE   = 3'd3;
   localparam logic [2:0] REG_IRQ_ENABLE     = 3'd4;
   localparam logic [2:0] REG_CAPTURE_ENABLE = 3'd5;
   localparam logic [2:0] REG_FILTER_SAMPLES = 3'd6;

   // status flag bit positions
   localparam int unsigned FLAG_UPDATE  = 0;
   localparam int unsigned FLAG_CAPTURE = 1;
   localparam int unsigned FLAG_COMPARE = 2;

   typedef struct packed {
      logic [15:0] prescale;
      logic [15:0] auto_reload;
      logic [15:0] compare_value;
      logic [2:0]  compare_mode;
      logic [2:0]  irq_enable;
      logic        capture_enable;
      logic [3:0]  filter_samples;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prescale:       16'd0,
      auto_reload:    16'hFFFF,
      compare_value:  16'd0,
      compare_mode:   MODE_FROZEN,
      irq_enable:     3'd0,
      capture_enable: 1'b0,
      filter_samples: 4'd1
   };

   // one request as it is executed against the timer state
   typedef struct packed {
      logic       fire;
      logic [2:0] func;
      logic       pin_level;
   } step_type;

   // flag events raised by the counter
   typedef struct packed {
      logic update;
      logic compare;
   } cnt_event_type;

endpackage

// File: hw/rtl/tcc_counter.sv
// ---------------------------------------------------------------------------
// tcc_counter
// prescaler, up counter with auto-reload, compare match and output pin
// ---------------------------------------------------------------------------
module tcc_counter #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcc_pkg::cfg_type         cfg,
   input  tcc_pkg::step_type        step,
   output logic [COUNT_WIDTH-1:0]   count_next,
   output logic                     running_next,
   output logic                     pin_next,
   output tcc_pkg::cnt_event_type   events
);
   import tcc_pkg::*;

   logic [15:0]            psc_ff, psc_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   pin_ff, pin_in;
   logic [COUNT_WIDTH-1:0] adv_cnt;
   logic                   adv_update;

   // count step: wrap at auto-reload, otherwise increment at counter width
   always_comb begin
      adv_update = 32'(cnt_ff) == 32'(cfg.auto_reload);
      adv_cnt    = adv_update ? '0 : cnt_ff + 1'b1;
   end

   // next state for one request
   always_comb begin
      psc_in = psc_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      pin_in = pin_ff;
      events = '0;
      if (step.fire) begin
         case (step.func)
            FUNC_TICK: begin
               if (run_ff) begin
                  if (psc_ff >= cfg.prescale) begin
                     psc_in        = '0;
                     cnt_in        = adv_cnt;
                     events.update = adv_update;
                     if (32'(adv_cnt) == 32'(cfg.compare_value)) begin
                        events.compare = 1'b1;
                        case (cfg.compare_mode)
                           MODE_SET:    pin_in = 1'b1;
                           MODE_CLEAR:  pin_in = 1'b0;
                           MODE_TOGGLE: pin_in = ~pin_ff;
                           default:     pin_in = pin_ff;
                        endcase
                     end
                  end else begin
                     psc_in = psc_ff + 16'd1;
                  end
               end
            end
            FUNC_START: run_in = 1'b1;
            FUNC_STOP: begin
               run_in = 1'b0;
               cnt_in = '0;
               psc_in = '0;
            end
            default: ;
         endcase
         // pwm level follows the final count of every request
         if (cfg.compare_mode == MODE_PWM) begin
            pin_in = 32'(cnt_in) < 32'(cfg.compare_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         psc_ff <= '0;
         cnt_ff <= '0;
         run_ff <= 1'b0;
         pin_ff <= 1'b0;
      end else begin
         psc_ff <= psc_in;
         cnt_ff <= cnt_in;
         run_ff <= run_in;
         pin_ff <= pin_in;
      end
   end

   assign count_next   = cnt_in;
   assign running_next = run_in;
   assign pin_next     = pin_in;

endmodule

// File: hw/rtl/tcc_capture.sv
// ---------------------------------------------------------------------------
// tcc_capture
// input pin glitch filter and rising-edge capture latch
// ---------------------------------------------------------------------------
module tcc_capture #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcc_pkg::cfg_type       cfg,
   input  tcc_pkg::step_type      step,
   input  logic [COUNT_WIDTH-1:0] count_next,
   output logic [15:0]            latch_next,
   output logic                   capture_hit
);
   import tcc_pkg::*;

   logic [3:0]  run_ff, run_in;
   logic        filt_ff, filt_in;
   logic [15:0] latch_ff, latch_in;
   logic [3:0]  need;
   logic [3:0]  run_inc;
   logic [31:0] count_wide;

   // filter runs on every tick, running or not
   always_comb begin
      need        = (cfg.filter_samples == 4'd0) ? 4'd1 : cfg.filter_samples;
      run_inc     = run_ff + 4'd1;
      count_wide  = 32'(count_next);
      run_in      = run_ff;
      filt_in     = filt_ff;
      latch_in    = latch_ff;
      capture_hit = 1'b0;
      if (step.fire && step.func == FUNC_TICK) begin
         if (step.pin_level == filt_ff) begin
            run_in = 4'd0;
         end else begin
            run_in = run_inc;
            if (run_inc >= need) begin
               run_in  = 4'd0;
               filt_in = step.pin_level;
               // capture the count after this tick's advance
               if (step.pin_level && cfg.capture_enable) begin
                  latch_in    = count_wide[15:0];
                  capture_hit = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         filt_ff  <= 1'b0;
         latch_ff <= '0;
      end else begin
         run_ff   <= run_in;
         filt_ff  <= filt_in;
         latch_ff <= latch_in;
      end
   end

   assign latch_next = latch_in;

endmodule

// File: hw/rtl/timer_compare_capture_pwm_top.sv
// ---------------------------------------------------------------------------
// timer_compare_capture_pwm_top
// general purpose timer: prescaler, up counter, compare/pwm and capture
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   func, pin_level, clear_mask
//  rsp      out        rsp_valid/rsp_ready   count, capture, flags, irq, pins
//  csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
//  one request per cycle sustained while rsp_ready holds; a request moves
//  from the input register to the response register as the timer state
//  updates on it, and that update sets the rate
//  a response waiting on rsp_ready lets one more request into the input
//  register, then req_ready drops until the response is taken
//  synchronous reset clears valids and timer state and loads register defaults
//  csr writes are always ready and take effect at once
// ---------------------------------------------------------------------------
module timer_compare_capture_pwm_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic        req_pin_level,
   input  logic [2:0]  req_clear_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_count_now,
   output logic [15:0] rsp_captured_count,
   output logic [2:0]  rsp_flags,
   output logic        rsp_irq,
   output logic        rsp_out_level,
   output logic        rsp_is_running,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tcc_pkg::*;

   cfg_type                cfg_ff;
   logic                   s1_valid_ff;
   logic [2:0]             s1_func_ff;
   logic                   s1_pin_ff;
   logic [2:0]             s1_mask_ff;
   logic                   advance;
   step_type               step;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   running_next;
   logic                   pin_next;
   cnt_event_type          events;
   logic [15:0]            latch_next;
   logic                   capture_hit;
   logic [2:0]             flags_ff, flags_in;
   logic [31:0]            count_wide;
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_count_ff, rsp_capture_ff;
   logic [2:0]             rsp_flags_ff;
   logic                   rsp_irq_ff, rsp_level_ff, rsp_running_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PRESCALE:       cfg_ff.prescale       <= csr_wdata;
            REG_AUTO_RELOAD:    cfg_ff.auto_reload    <= csr_wdata;
            REG_COMPARE_VALUE:  cfg_ff.compare_value  <= csr_wdata;
            REG_COMPARE_MODE:   cfg_ff.compare_mode   <= csr_wdata[2:0];
            REG_IRQ_ENABLE:     cfg_ff.irq_enable     <= csr_wdata[2:0];
            REG_CAPTURE_ENABLE: cfg_ff.capture_enable <= csr_wdata[0];
            REG_FILTER_SAMPLES: cfg_ff.filter_samples <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // input register, refills in the cycle it drains
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff <= req_func;
         s1_pin_ff  <= req_pin_level;
         s1_mask_ff <= req_clear_mask;
      end
   end

   assign step = '{fire: advance, func: s1_func_ff, pin_level: s1_pin_ff};

   tcc_counter #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_counter (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .step         (step),
      .count_next   (count_next),
      .running_next (running_next),
      .pin_next     (pin_next),
      .events       (events)
   );

   tcc_capture #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .step        (step),
      .count_next  (count_next),
      .latch_next  (latch_next),
      .capture_hit (capture_hit)
   );

   // status flags: set by events, cleared by mask
   always_comb begin
      flags_in = flags_ff;
      if (advance) begin
         flags_in[FLAG_UPDATE]  = flags_ff[FLAG_UPDATE] | events.update;
         flags_in[FLAG_COMPARE] = flags_ff[FLAG_COMPARE] | events.compare;
         flags_in[FLAG_CAPTURE] = flags_ff[FLAG_CAPTURE] | capture_hit;
         if (s1_func_ff == FUNC_CLEAR) begin
            flags_in = flags_in & ~s1_mask_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // response register
   assign count_wide = 32'(count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_count_ff   <= count_wide[15:0];
         rsp_capture_ff <= latch_next;
         rsp_flags_ff   <= flags_in;
         rsp_irq_ff     <= |(flags_in & cfg_ff.irq_enable);
         rsp_level_ff   <= pin_next;
         rsp_running_ff <= running_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_count_now      = rsp_count_ff;
   assign rsp_captured_count = rsp_capture_ff;
   assign rsp_flags          = rsp_flags_ff;
   assign rsp_irq            = rsp_irq_ff;
   assign rsp_out_level      = rsp_level_ff;
   assign rsp_is_running     = rsp_running_ff;

endmodule

// File: hw/rtl/tcc_checker.sv
// ---------------------------------------------------------------------------
// tcc_checker
// port-level checks on the timer, bound to the top level
// ---------------------------------------------------------------------------
`include "timer_compare_capture_pwm_top_defines.svh"

module tcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_count_now,
   input logic [2:0]  rsp_flags,
   input logic        rsp_irq,
   input logic        rsp_is_running
);

   // a stalled response holds
   `TCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count_now) && $stable(rsp_flags))

   // interrupt needs a set flag
   `TCC_ASSERT_IMP(a_irq_flag, clock, reset, rsp_valid && rsp_irq, rsp_flags != 3'd0)

   // a stopped timer always shows a cleared count
   `TCC_ASSERT_IMP(a_stopped_zero, clock, reset, rsp_valid && !rsp_is_running, rsp_count_now == 16'd0)

   // both stages full behind a stalled response block requests until it drains
   `TCC_ASSERT_NEXT(a_full_stall, clock, reset, rsp_valid && !rsp_ready && req_valid && req_ready, !req_ready || rsp_ready)

   // reset empties the pipeline
   `TCC_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind timer_compare_capture_pwm_top tcc_checker u_tcc_checker (.*);

// File: tb/tb_timer_compare_capture_pwm_top.sv
// ---------------------------------------------------------------------------
// tb_timer_compare_capture_pwm_top
// self-checking bench for the timer with compare, capture and pwm channels
// ---------------------------------------------------------------------------
//  requests are queued by the main sequence and driven on the falling edge;
//  a clocked monitor predicts every accepted request against a timer model
//  kept in step with each csr write, and compares responses in order.
//  the run starts with a directed sequence, then random request streams under
//  a series of register settings; two of three profiles stall both sides at random
// ---------------------------------------------------------------------------
module tb_timer_compare_capture_pwm_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcc_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;

   typedef struct packed {
      logic [2:0] func;
      logic       pin_level;
      logic [2:0] clear_mask;
   } timer_req_type;

   typedef struct packed {
      logic [15:0] count_now;
      logic [15:0] captured_count;
      logic [2:0]  flags;
      logic        irq;
      logic        out_level;
      logic        is_running;
   } timer_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic        req_pin_level;
   logic [2:0]  req_clear_mask;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_count_now;
   logic [15:0] rsp_captured_count;
   logic [2:0]  rsp_flags;
   logic        rsp_irq;
   logic        rsp_out_level;
   logic        rsp_is_running;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // request stream and expected responses
   timer_req_type pending_reqs[$];
   timer_rsp_type expected_rsps[$];
   int unsigned reqs_queued;
   int unsigned reqs_taken;
   int unsigned error_count;
   int unsigned stall_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   logic        req_fired;
   logic        csr_fired;

   // timer model state and its copy of the registers
   cfg_type     cfg_now;
   logic [15:0] m_prescale_cnt;
   logic [15:0] m_counter;
   logic        m_running;
   logic [2:0]  m_flags;
   logic        m_out_pin;
   logic [15:0] m_capture;
   logic [3:0]  m_filt_run;
   logic        m_filt_pin;

   timer_compare_capture_pwm_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_pin_level      (req_pin_level),
      .req_clear_mask     (req_clear_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_count_now      (rsp_count_now),
      .rsp_captured_count (rsp_captured_count),
      .rsp_flags          (rsp_flags),
      .rsp_irq            (rsp_irq),
      .rsp_out_level      (rsp_out_level),
      .rsp_is_running     (rsp_is_running),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one request to the timer model and return the response it gives
   function automatic timer_rsp_type advance_timer(input logic [2:0] func, input logic pin,
                                                   input logic [2:0] mask);
      timer_rsp_type r;
      logic [3:0] need;
      case (func)
         FUNC_TICK: begin
            if (m_running) begin
               if (m_prescale_cnt >= cfg_now.prescale) begin
                  m_prescale_cnt = '0;
                  // wrap at auto reload, otherwise count on at full width
                  if (m_counter == cfg_now.auto_reload) begin
                     m_counter = '0;
                     m_flags[FLAG_UPDATE] = 1'b1;
                  end else begin
                     m_counter = m_counter + 16'd1;
                  end
                  if (m_counter == cfg_now.compare_value) begin
                     m_flags[FLAG_COMPARE] = 1'b1;
                     case (cfg_now.compare_mode)
                        MODE_SET:    m_out_pin = 1'b1;
                        MODE_CLEAR:  m_out_pin = 1'b0;
                        MODE_TOGGLE: m_out_pin = ~m_out_pin;
                        default:     ;
                     endcase
                  end
               end else begin
                  m_prescale_cnt = m_prescale_cnt + 16'd1;
               end
            end
            // pin filter runs on every tick, running or not
            need = (cfg_now.filter_samples == 4'd0) ? 4'd1 : cfg_now.filter_samples;
            if (pin == m_filt_pin) begin
               m_filt_run = '0;
            end else begin
               m_filt_run = m_filt_run + 4'd1;
               if (m_filt_run >= need) begin
                  m_filt_run = '0;
                  m_filt_pin = pin;
                  if (pin && cfg_now.capture_enable) begin
                     m_capture = m_counter;
                     m_flags[FLAG_CAPTURE] = 1'b1;
                  end
               end
            end
         end
         FUNC_START: m_running = 1'b1;
         FUNC_STOP: begin
            m_running      = 1'b0;
            m_counter      = '0;
            m_prescale_cnt = '0;
         end
         FUNC_CLEAR: m_flags = m_flags & ~mask;
         default: ;
      endcase
      if (cfg_now.compare_mode == MODE_PWM)
         m_out_pin = (m_counter < cfg_now.compare_value);
      r.count_now      = m_counter;
      r.captured_count = m_capture;
      r.flags          = m_flags;
      r.irq            = |(m_flags & cfg_now.irq_enable);
      r.out_level      = m_out_pin;
      r.is_running     = m_running;
      return r;
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   // request driver and response back-pressure, both on the falling edge
   always @(negedge clock) begin
      timer_req_type nxt;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && (!req_valid || req_fired)) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_func       <= nxt.func;
            req_pin_level  <= nxt.pin_level;
            req_clear_mask <= nxt.clear_mask;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: register shadow, prediction, response check and watchdog
   always @(posedge clock) begin
      timer_rsp_type want;
      if (reset) begin
         cfg_now        = CFG_RESET;
         m_prescale_cnt = '0;
         m_counter      = '0;
         m_running      = 1'b0;
         m_flags        = '0;
         m_out_pin      = 1'b0;
         m_capture      = '0;
         m_filt_run     = '0;
         m_filt_pin     = 1'b0;
         stall_cycles   = 0;
         req_fired <= 1'b0;
         csr_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         csr_fired <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PRESCALE:       cfg_now.prescale       = csr_wdata;
               REG_AUTO_RELOAD:    cfg_now.auto_reload    = csr_wdata;
               REG_COMPARE_VALUE:  cfg_now.compare_value  = csr_wdata;
               REG_COMPARE_MODE:   cfg_now.compare_mode   = csr_wdata[2:0];
               REG_IRQ_ENABLE:     cfg_now.irq_enable     = csr_wdata[2:0];
               REG_CAPTURE_ENABLE: cfg_now.capture_enable = csr_wdata[0];
               REG_FILTER_SAMPLES: cfg_now.filter_samples = csr_wdata[3:0];
               default: ;
            endcase
         end
         // responses belong to earlier requests, so check before predicting
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("count_now", want.count_now, rsp_count_now);
               check_field("captured_count", want.captured_count, rsp_captured_count);
               check_field("flags", want.flags, rsp_flags);
               check_field("irq", want.irq, rsp_irq);
               check_field("out_level", want.out_level, rsp_out_level);
               check_field("is_running", want.is_running, rsp_is_running);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(advance_timer(req_func, req_pin_level, req_clear_mask));
            reqs_taken++;
         end
         // watchdog only counts while work is outstanding
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
             || (reqs_taken == reqs_queued && expected_rsps.size() == 0 && !csr_valid)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t: watchdog expired", $time);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   task automatic queue_req(input logic [2:0] func, input logic pin, input logic [2:0] mask);
      timer_req_type r;
      r.func       = func;
      r.pin_level  = pin;
      r.clear_mask = mask;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // block until every request is answered, then let the pipeline drain
   task automatic wait_idle();
      while (reqs_taken != reqs_queued || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // write all seven registers back to back; called on a falling edge
   task automatic write_cfg(input cfg_type c);
      csr_valid <= 1'b1;
      for (int i = 0; i < 7; i++) begin
         // narrow registers get random upper bits, which must be ignored
         case (i)
            0: begin
               csr_index <= REG_PRESCALE;
               csr_wdata <= c.prescale;
            end
            1: begin
               csr_index <= REG_AUTO_RELOAD;
               csr_wdata <= c.auto_reload;
            end
            2: begin
               csr_index <= REG_COMPARE_VALUE;
               csr_wdata <= c.compare_value;
            end
            3: begin
               csr_index <= REG_COMPARE_MODE;
               csr_wdata <= {13'($urandom()), c.compare_mode};
            end
            4: begin
               csr_index <= REG_IRQ_ENABLE;
               csr_wdata <= {13'($urandom()), c.irq_enable};
            end
            5: begin
               csr_index <= REG_CAPTURE_ENABLE;
               csr_wdata <= {15'($urandom()), c.capture_enable};
            end
            default: begin
               csr_index <= REG_FILTER_SAMPLES;
               csr_wdata <= {12'($urandom()), c.filter_samples};
            end
         endcase
         @(negedge clock);
         while (!csr_fired) @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // register settings: fixed extremes for some indexes, random small timers otherwise
   function automatic cfg_type pick_cfg(input int k);
      cfg_type c;
      c.prescale       = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(3, 6)) :
                                                       16'($urandom_range(0, 2));
      c.auto_reload    = 16'($urandom_range(0, 40));
      c.compare_value  = 16'($urandom_range(0, int'(c.auto_reload) + 3));
      c.compare_mode   = 3'($urandom_range(0, 7));
      c.irq_enable     = 3'($urandom_range(0, 7));
      c.capture_enable = ($urandom_range(0, 3) != 0);
      c.filter_samples = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15)) :
                                                       4'($urandom_range(0, 8));
      case (k)
         0: c = '{16'd0, 16'd0, 16'd0, MODE_TOGGLE, 3'd7, 1'b1, 4'd0};
         // counter stalls behind the largest prescale while its count builds up
         1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_PWM, 3'd7, 1'b1, 4'd15};
         // prescale dropped below the running prescale count
         2: c = '{16'd0, 16'd9, 16'd3, MODE_PWM, 3'd2, 1'b1, 4'd1};
         5: c = '{16'd0, 16'd5, 16'hFFFF, MODE_SET, 3'd1, 1'b0, 4'd2};
         7: c = '{16'd1, 16'd6, 16'd6, MODE_CLEAR, 3'd4, 1'b1, 4'd3};
         default: ;
      endcase
      return c;
   endfunction

   // random stream: mostly ticks with the pin held in runs, so the filter
   // sees both steady levels and single-tick glitches
   task automatic queue_random_reqs(input int n);
      int          roll;
      int          run_left;
      logic        pin_now;
      logic [2:0]  fn;
      run_left = 0;
      pin_now  = 1'($urandom_range(0, 1));
      queue_req(FUNC_START, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      for (int i = 1; i < n; i++) begin
         if (run_left == 0) begin
            pin_now  = ~pin_now;
            run_left = $urandom_range(1, 20);
         end
         roll = $urandom_range(0, 99);
         if (roll < 72) fn = FUNC_TICK;
         else if (roll < 76) fn = FUNC_START;
         else if (roll < 79) fn = FUNC_STOP;
         else if (roll < 90) fn = FUNC_CLEAR;
         else if (roll < 97) fn = FUNC_READ;
         else fn = 3'($urandom_range(5, 7));  // unused codes
         if (fn == FUNC_TICK) run_left--;
         queue_req(fn, (fn == FUNC_TICK) ? pin_now : 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)));
      end
   endtask

   // main sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_TICK;
      req_pin_level  = 1'b0;
      req_clear_mask = '0;
      rsp_ready      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = REG_PRESCALE;
      csr_wdata      = '0;
      reqs_queued    = 0;
      reqs_taken     = 0;
      error_count    = 0;
      send_idle_pct  = 29;
      recv_idle_pct  = 73;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: filter while stopped, repeated start and stop, wrap and
      // toggle on match, clears by mask and the unused function codes
      write_cfg('{16'd1, 16'd3, 16'd2, MODE_TOGGLE, 3'd7, 1'b1, 4'd2});
      queue_req(FUNC_READ, 1'b1, 3'd7);
      queue_req(FUNC_TICK, 1'b1, 3'd0);
      queue_req(FUNC_TICK, 1'b1, 3'd0);
      queue_req(FUNC_START, 1'b0, 3'd5);
      queue_req(FUNC_START, 1'b1, 3'd2);
      queue_req(FUNC_TICK, 1'b1, 3'd7);
      queue_req(FUNC_TICK, 1'b0, 3'd0);
      queue_req(FUNC_TICK, 1'b0, 3'd7);
      queue_req(FUNC_TICK, 1'b1, 3'd0);
      queue_req(FUNC_TICK, 1'b1, 3'd7);
      queue_req(FUNC_TICK, 1'b1, 3'd0);
      queue_req(FUNC_TICK, 1'b0, 3'd7);
      queue_req(FUNC_TICK, 1'b1, 3'd0);
      queue_req(FUNC_CLEAR, 1'b1, 3'b001);
      queue_req(FUNC_CLEAR, 1'b0, 3'b110);
      queue_req(3'd5, 1'b1, 3'd7);
      queue_req(3'd6, 1'b0, 3'd0);
      queue_req(3'd7, 1'b1, 3'd7);
      queue_req(FUNC_STOP, 1'b0, 3'd0);
      queue_req(FUNC_STOP, 1'b1, 3'd7);
      queue_req(FUNC_TICK, 1'b0, 3'd0);
      queue_req(FUNC_CLEAR, 1'b0, 3'b111);
      queue_req(FUNC_READ, 1'b0, 3'd0);

      // random streams in three stall profiles, four settings each
      for (int part = 0; part < 3; part++) begin
         for (int k = 0; k < 4; k++) begin
            wait_idle();
            if (k == 0) begin
               send_idle_pct = (part == 0) ? 29 : (part == 1) ? 73 : 0;
               recv_idle_pct = (part == 0) ? 73 : (part == 1) ? 29 : 0;
            end
            write_cfg(pick_cfg(part * 4 + k));
            queue_random_reqs(125);
         end
      end

      wait_idle();
      repeat (5) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
